// ===== rtl/core/sahw_pkg.sv =====
package sahw_pkg;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_FULL = 2'd1;
	localparam logic [1:0] STATUS_FREE = 2'd2;

	localparam int SLOT_W  = 5;
	localparam int COUNT_W = 6;
	localparam int LIMIT_W = 6;

	localparam logic [LIMIT_W-1:0] CROWD_LIMIT_RESET = 6'd27;

	// controller to datapath
	typedef struct packed {
		logic take;          // latch the requested slot
		logic ptr_zero;      // restart the scan pointer at slot 0
		logic ptr_inc;
		logic ptr_dec;
		logic ptr_below;     // pointer to the slot under the requested one
		logic rd_en;
		logic rd_req;        // read at the requested slot rather than the pointer
		logic clr_wr;        // clearing pass write
		logic alloc_commit;  // take the slot under the tag
		logic full_set;
		logic bad_set;
		logic free_commit;   // release the requested slot
		logic high_from_tag;
		logic high_zero;
		logic out_load;
	} sahw_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic rdata;         // occupancy bit of the slot under the tag
		logic ptr_ok;        // pointer names a real slot
		logic ptr_last;
		logic tag_first;
		logic tag_last;
		logic req_ok;        // requested slot exists
		logic high_at_req;   // requested slot is the topmost occupied one
	} sahw_sts_t;

endpackage

// ===== rtl/core/sahw_ram.sv =====
module sahw_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/sahw_dpath.sv =====
module sahw_dpath
	import sahw_pkg::*;
#(
	parameter int SLOTS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sahw_cmd_t          cmd,
	output sahw_sts_t          sts,
	input  logic [SLOT_W-1:0]  slot,
	input  logic               cfg_we,
	input  logic [LIMIT_W-1:0] cfg_data,
	output logic [1:0]         status,
	output logic [SLOT_W-1:0]  slot_index,
	output logic [COUNT_W-1:0] online_count,
	output logic [COUNT_W-1:0] high_mark,
	output logic               crowded
);

	localparam int AW = $clog2(SLOTS);
	localparam int PW = AW + 1;
	localparam int CW = $clog2(SLOTS + 1);

	logic [PW-1:0]      ptr_q;
	logic [AW-1:0]      tag_q;
	logic [SLOT_W-1:0]  req_q;
	logic [CW-1:0]      online_q;
	logic [CW-1:0]      high_q;
	logic [LIMIT_W-1:0] crowd_q;
	logic [1:0]         res_status_q;
	logic [SLOT_W-1:0]  res_idx_q;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic          mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic          mem_rdata;

	sahw_ram #(
		.WIDTH(1),
		.DEPTH(SLOTS)
	) u_occ (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (cmd.rd_en),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_comb begin
		mem_we    = cmd.clr_wr | cmd.alloc_commit | cmd.free_commit;
		mem_wdata = cmd.alloc_commit;
		priority if (cmd.clr_wr) begin
			mem_waddr = ptr_q[AW-1:0];
		end else if (cmd.alloc_commit) begin
			mem_waddr = tag_q;
		end else begin
			mem_waddr = AW'(req_q);
		end
		mem_raddr = cmd.rd_req ? AW'(req_q) : ptr_q[AW-1:0];
	end

	always_comb begin
		sts.rdata       = mem_rdata;
		sts.ptr_ok      = 32'(ptr_q) < SLOTS;
		sts.ptr_last    = ptr_q == PW'(SLOTS - 1);
		sts.tag_first   = tag_q == '0;
		sts.tag_last    = tag_q == AW'(SLOTS - 1);
		sts.req_ok      = 32'(req_q) < SLOTS;
		sts.high_at_req = 32'(high_q) == 32'(req_q) + 32'd1;
	end

	// scan pointer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q    <= '0;
			online_q <= '0;
			high_q   <= '0;
			crowd_q  <= CROWD_LIMIT_RESET;
		end else begin
			priority if (cmd.ptr_zero) begin
				ptr_q <= '0;
			end else if (cmd.ptr_below) begin
				ptr_q <= PW'(32'(req_q) - 32'd1);
			end else if (cmd.ptr_inc) begin
				ptr_q <= ptr_q + PW'(1);
			end else if (cmd.ptr_dec) begin
				ptr_q <= ptr_q - PW'(1);
			end else begin
				ptr_q <= ptr_q;
			end
			if (cmd.alloc_commit) begin
				online_q <= online_q + CW'(1);
			end else if (cmd.free_commit) begin
				if (online_q != '0) begin
					online_q <= online_q - CW'(1);
				end
			end
			priority if (cmd.high_from_tag) begin
				high_q <= CW'(32'(tag_q) + 32'd1);
			end else if (cmd.high_zero) begin
				high_q <= '0;
			end else if (cmd.alloc_commit && (32'(tag_q) + 32'd1 > 32'(high_q))) begin
				high_q <= CW'(32'(tag_q) + 32'd1);
			end else begin
				high_q <= high_q;
			end
			if (cfg_we) begin
				crowd_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			tag_q <= mem_raddr;
		end
		if (cmd.take) begin
			req_q <= slot;
		end
		priority if (cmd.alloc_commit) begin
			res_status_q <= STATUS_OK;
			res_idx_q    <= SLOT_W'(tag_q);
		end else if (cmd.full_set) begin
			res_status_q <= STATUS_FULL;
			res_idx_q    <= '0;
		end else if (cmd.bad_set) begin
			res_status_q <= STATUS_FREE;
			res_idx_q    <= req_q;
		end else if (cmd.free_commit) begin
			res_status_q <= STATUS_OK;
			res_idx_q    <= req_q;
		end else begin
			res_status_q <= res_status_q;
			res_idx_q    <= res_idx_q;
		end
		if (cmd.out_load) begin
			status       <= res_status_q;
			slot_index   <= res_idx_q;
			online_count <= COUNT_W'(online_q);
			high_mark    <= COUNT_W'(high_q);
			crowded      <= 32'(online_q) > 32'(crowd_q);
		end
	end

endmodule

// ===== rtl/core/sahw_ctrl.sv =====
module sahw_ctrl
	import sahw_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic      operation,
	output logic      out_valid,
	input  logic      out_ready,
	input  sahw_sts_t sts,
	output sahw_cmd_t cmd
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_ASCAN = 3'd2;
	localparam logic [2:0] ST_FRD   = 3'd3;
	localparam logic [2:0] ST_FCHK  = 3'd4;
	localparam logic [2:0] ST_HSCAN = 3'd5;
	localparam logic [2:0] ST_EMIT  = 3'd6;

	logic [2:0] state_q, state_d;
	logic       rdv_q, rdv_d;
	logic       out_valid_q;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		rdv_d    = 1'b0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr  = 1'b1;
				cmd.ptr_inc = 1'b1;
				if (sts.ptr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take     = 1'b1;
					cmd.ptr_zero = 1'b1;
					state_d      = (operation == OP_ALLOC) ? ST_ASCAN : ST_FRD;
				end
			end
			ST_ASCAN: begin
				cmd.rd_en   = sts.ptr_ok;
				cmd.ptr_inc = sts.ptr_ok;
				rdv_d       = sts.ptr_ok;
				priority if (rdv_q && !sts.rdata) begin
					cmd.alloc_commit = 1'b1;
					state_d          = ST_EMIT;
				end else if (rdv_q && sts.tag_last) begin
					cmd.full_set = 1'b1;
					state_d      = ST_EMIT;
				end else begin
					state_d = state_q;
				end
			end
			ST_FRD: begin
				if (!sts.req_ok) begin
					cmd.bad_set = 1'b1;
					state_d     = ST_EMIT;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_req = 1'b1;
					state_d    = ST_FCHK;
				end
			end
			ST_FCHK: begin
				if (!sts.rdata) begin
					cmd.bad_set = 1'b1;
					state_d     = ST_EMIT;
				end else begin
					cmd.free_commit = 1'b1;
					if (sts.high_at_req) begin
						cmd.ptr_below = 1'b1;
						state_d       = ST_HSCAN;
					end else begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_HSCAN: begin
				cmd.rd_en   = sts.ptr_ok;
				cmd.ptr_dec = sts.ptr_ok;
				rdv_d       = sts.ptr_ok;
				priority if (rdv_q && sts.rdata) begin
					cmd.high_from_tag = 1'b1;
					state_d           = ST_EMIT;
				end else if ((rdv_q && sts.tag_first) || (!rdv_q && !sts.ptr_ok)) begin
					cmd.high_zero = 1'b1;
					state_d       = ST_EMIT;
				end else begin
					state_d = state_q;
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			rdv_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rdv_q   <= rdv_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/core/slot_allocator_high_water_core.sv =====
// Channel   Handshake             Payload
// -------   -------------------   ---------------------------------------------------
// in        in_valid / in_ready   operation, slot
// out       out_valid / out_ready status, slot_index, online_count, high_mark, crowded
// cfg       cfg_we (no wait)      cfg_data -> crowd limit
//
// One item at a time. An allocate scans up from slot 0 and returns its result once it
// finds a free slot or has read the last one. A free reads the requested slot; releasing the
// topmost occupied slot adds a walk down, slot by slot, to the new mark.
// The occupancy RAM has one read port, so every scan visits one slot per cycle.
// After reset a clearing pass over every slot empties the RAM; in_ready stays low.
// A finished result waits in the output register; the next one holds until out_ready.
module slot_allocator_high_water_core
	import sahw_pkg::*;
#(
	parameter int SLOTS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               operation,
	input  logic [SLOT_W-1:0]  slot,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic [SLOT_W-1:0]  slot_index,
	output logic [COUNT_W-1:0] online_count,
	output logic [COUNT_W-1:0] high_mark,
	output logic               crowded,
	input  logic               cfg_we,
	input  logic [LIMIT_W-1:0] cfg_data
);

	sahw_cmd_t cmd;
	sahw_sts_t sts;

	// sequencer: clearing pass, request decode, scan control, result hand-off
	sahw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// occupancy RAM, scan pointer, online count, high-water mark, output register
	sahw_dpath #(
		.SLOTS(SLOTS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.slot         (slot),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.status       (status),
		.slot_index   (slot_index),
		.online_count (online_count),
		.high_mark    (high_mark),
		.crowded      (crowded)
	);

endmodule

// ===== rtl/core/sahw_checker.sv =====
module sahw_checker
	import sahw_pkg::*;
#(
	parameter int SLOTS = 32
) (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [1:0]         status,
	input logic [SLOT_W-1:0]  slot_index,
	input logic [COUNT_W-1:0] online_count,
	input logic [COUNT_W-1:0] high_mark
);

	// a waiting result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(slot_index)
			&& $stable(online_count) && $stable(high_mark))
		else $error("result changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == STATUS_OK || status == STATUS_FULL || status == STATUS_FREE)
		else $error("undefined status code");

	a_full_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_FULL |-> slot_index == '0)
		else $error("full result carries a slot");

	// one item at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item accepted while busy");

	a_count_below_mark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> SLOTS > 63 || online_count <= high_mark)
		else $error("online count above high-water mark");

endmodule

bind slot_allocator_high_water_core sahw_checker #(
	.SLOTS(SLOTS)
) u_sahw_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.status       (status),
	.slot_index   (slot_index),
	.online_count (online_count),
	.high_mark    (high_mark)
);

// ===== tb/sv/sahw_checker.sv =====
module sahw_scoreboard
	import sahw_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               operation,
	input  logic [SLOT_W-1:0]  slot,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [1:0]         status,
	input  logic [SLOT_W-1:0]  slot_index,
	input  logic [COUNT_W-1:0] online_count,
	input  logic [COUNT_W-1:0] high_mark,
	input  logic               crowded,
	input  logic               cfg_we,
	input  logic [LIMIT_W-1:0] cfg_data,
	output int                 errors,
	output int                 outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_SLOTS = 32;

	typedef struct packed {
		logic [1:0]         status;
		logic [SLOT_W-1:0]  slot_index;
		logic [COUNT_W-1:0] online_count;
		logic [COUNT_W-1:0] high_mark;
		logic               crowded;
	} slot_result_t;

	logic [TABLE_SLOTS-1:0] taken;
	logic [COUNT_W-1:0]     online;
	logic [COUNT_W-1:0]     high_water;
	logic [LIMIT_W-1:0]     crowd_limit;

	slot_result_t awaited_results[$];
	slot_result_t oldest;
	int           accepted_items;
	int           returned_items;

	assign outstanding = accepted_items - returned_items;

	initial errors = 0;

	// first fit on allocate; on release walk the mark down past trailing free slots
	function automatic slot_result_t allot_or_release(input logic op,
			input logic [SLOT_W-1:0] req);
		slot_result_t r;
		int           pick;
		r.status     = STATUS_OK;
		r.slot_index = req;
		if (op == OP_ALLOC) begin
			pick = -1;
			for (int i = 0; i < TABLE_SLOTS; i++) begin
				if (!taken[i]) begin
					pick = i;
					break;
				end
			end
			if (pick < 0) begin
				r.status     = STATUS_FULL;
				r.slot_index = '0;
			end else begin
				taken[pick] = 1'b1;
				online      = online + COUNT_W'(1);
				if (pick + 1 > high_water)
					high_water = COUNT_W'(pick + 1);
				r.slot_index = SLOT_W'(pick);
			end
		end else if (!taken[req]) begin
			r.status = STATUS_FREE;
		end else begin
			taken[req] = 1'b0;
			if (online != 0)
				online = online - COUNT_W'(1);
			while (high_water != 0 && !taken[SLOT_W'(high_water - COUNT_W'(1))])
				high_water = high_water - COUNT_W'(1);
		end
		r.online_count = online;
		r.high_mark    = high_water;
		r.crowded      = (online > crowd_limit);
		return r;
	endfunction

	function automatic void compare_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken       = '0;
			online      = '0;
			high_water  = '0;
			crowd_limit = CROWD_LIMIT_RESET;
			awaited_results.delete();
			accepted_items <= 0;
			returned_items <= 0;
		end else begin
			if (cfg_we)
				crowd_limit = cfg_data;
			if (in_valid && in_ready) begin
				awaited_results.push_back(allot_or_release(operation, slot));
				accepted_items <= accepted_items + 1;
			end
			if (out_valid && out_ready) begin
				returned_items <= returned_items + 1;
				if (awaited_results.size() == 0) begin
					$display("%0t: result with none awaited, expected nothing, got status %0d slot %0d",
						$time, status, slot_index);
					errors++;
				end else begin
					oldest = awaited_results.pop_front();
					compare_field("status", oldest.status, status);
					compare_field("slot_index", oldest.slot_index, slot_index);
					compare_field("online_count", oldest.online_count, online_count);
					compare_field("high_mark", oldest.high_mark, high_mark);
					compare_field("crowded", oldest.crowded, crowded);
				end
			end
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import sahw_pkg::*;

	// Generous ceiling on the run length for the watchdog.
	localparam int CYCLE_LIMIT  = 200000;
	// Settle margin after a drain; it outlasts a full-table allocate scan.
	localparam int SETTLE       = 40;
	localparam int PHASE_ITEMS  = 75;
	localparam int HOLD_CYCLES  = 400;
	localparam int HOLD_AT      = 40;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               operation;
	logic [SLOT_W-1:0]  slot;
	logic               out_valid;
	logic               out_ready;
	logic [1:0]         status;
	logic [SLOT_W-1:0]  slot_index;
	logic [COUNT_W-1:0] online_count;
	logic [COUNT_W-1:0] high_mark;
	logic               crowded;
	logic               cfg_we;
	logic [LIMIT_W-1:0] cfg_data;

	int errors;
	int outstanding;
	int cycles;
	int results_taken;
	bit tx_fast;
	bit rx_fast;
	bit held;

	slot_allocator_high_water_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.slot         (slot),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.slot_index   (slot_index),
		.online_count (online_count),
		.high_mark    (high_mark),
		.crowded      (crowded),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data)
	);

	sahw_scoreboard u_scoreboard (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.slot         (slot),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.slot_index   (slot_index),
		.online_count (online_count),
		.high_mark    (high_mark),
		.crowded      (crowded),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.errors       (errors),
		.outstanding  (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog: count every rising edge and give up at the ceiling.
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
	end

	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	// Offer one request item. Draw a gap first unless the sender is in a burst
	// with no idling, then hold valid and the payload until the block takes it.
	task automatic offer(input logic op, input logic [SLOT_W-1:0] s);
		int gap;
		gap = tx_fast ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		slot      <= s;
		do @(posedge clk); while (in_ready !== 1'b1);
	endtask

	// Write the crowd limit only once the block has drained. Every request
	// returns exactly one result, so an empty scoreboard plus a settle margin
	// means the block is idle.
	task automatic set_crowd_limit(input logic [LIMIT_W-1:0] value);
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we   <= 1'b0;
	endtask

	// One phase of random traffic. Open with a fill run so the table reaches
	// full, then mix bursts that lean towards allocate, balanced, or towards
	// release. Releases favour the low slots, which first fit keeps busy.
	task automatic random_phase(input int count);
		int          left;
		int          len;
		int          lean;
		int          k;
		logic        op;
		logic [SLOT_W-1:0] s;
		left    = count;
		tx_fast = 1'b0;
		for (k = 0; k < 36; k++) begin
			op = ($urandom_range(0, 99) < 97) ? OP_ALLOC : OP_FREE;
			offer(op, SLOT_W'($urandom()));
		end
		left -= 36;
		while (left > 0) begin
			lean = $urandom_range(0, 2);
			len  = $urandom_range(8, 40);
			if (len > left)
				len = left;
			tx_fast = ($urandom_range(0, 3) == 0);
			for (k = 0; k < len; k++) begin
				case (lean)
					0: op = ($urandom_range(0, 99) < 90) ? OP_ALLOC : OP_FREE;
					1: op = ($urandom_range(0, 99) < 50) ? OP_ALLOC : OP_FREE;
					default: op = ($urandom_range(0, 99) < 15) ? OP_ALLOC : OP_FREE;
				endcase
				if ($urandom_range(0, 1) == 0)
					s = SLOT_W'($urandom_range(0, 7));
				else
					s = SLOT_W'($urandom());
				offer(op, s);
			end
			left -= len;
		end
	endtask

	// Result side: draw a stall per item, flip between idling and streaming
	// now and then, and once hold off for a long stretch so the block backs up.
	initial begin
		int gap;
		out_ready     = 1'b0;
		results_taken = 0;
		rx_fast       = 1'b0;
		held          = 1'b0;
		@(posedge arst_n);
		forever begin
			if (results_taken % 50 == 49)
				rx_fast = ($urandom_range(0, 2) == 0);
			gap = rx_fast ? 0 : $urandom_range(0, 11);
			if (!held && results_taken == HOLD_AT) begin
				held = 1'b1;
				gap  = HOLD_CYCLES;
			end
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			results_taken++;
		end
	end

	// Request side and verdict.
	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		operation = OP_ALLOC;
		slot      = '0;
		cfg_we    = 1'b0;
		cfg_data  = '0;
		tx_fast   = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed run under the reset crowd limit. Start by releasing slots
		// that are already free, at both ends of the index range.
		offer(OP_FREE, 5'd0);
		offer(OP_FREE, 5'd31);
		// Allocate ignores the slot field; drive it with ones and a mix.
		offer(OP_ALLOC, 5'd31);
		offer(OP_ALLOC, 5'd0);
		offer(OP_ALLOC, 5'd21);
		// Release from the middle: the mark must not move.
		offer(OP_FREE, 5'd1);
		// Double release of the same slot.
		offer(OP_FREE, 5'd1);
		// Release the topmost: the mark drops past the hole at slot 1.
		offer(OP_FREE, 5'd2);
		// First fit must reuse slot 1.
		offer(OP_ALLOC, 5'd10);
		offer(OP_FREE, 5'd0);
		// Last occupied slot goes: mark back to zero.
		offer(OP_FREE, 5'd1);
		offer(OP_FREE, 5'd0);
		offer(OP_ALLOC, 5'd0);
		offer(OP_ALLOC, 5'd0);
		offer(OP_ALLOC, 5'd0);
		offer(OP_FREE, 5'd2);
		offer(OP_FREE, 5'd0);
		offer(OP_FREE, 5'd1);
		// Release an out-of-use slot high in the table.
		offer(OP_FREE, 5'd16);

		// Sweep the limit: zero, out of range, just under full, exactly the
		// table size, one, then a random legal value.
		set_crowd_limit(6'd0);
		random_phase(PHASE_ITEMS);
		set_crowd_limit(6'd63);
		random_phase(PHASE_ITEMS);
		set_crowd_limit(6'd31);
		random_phase(PHASE_ITEMS);
		set_crowd_limit(6'd32);
		random_phase(PHASE_ITEMS);
		set_crowd_limit(6'd1);
		random_phase(PHASE_ITEMS);
		set_crowd_limit(LIMIT_W'($urandom_range(0, 32)));
		random_phase(PHASE_ITEMS);

		// Drain: wait for every result, then a settle margin for strays.
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
